/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// clocked on clk_i, reset by rst_ni (active low) in the including module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked only outside reset
`define AID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked during reset as well
`define AID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define AID_ASSERT(lbl, prop, msg)
`define AID_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* sv/aid_pkg.sv */
// ----------------------------------------------------------------------------
// aid_pkg: shared types and constants
// key register layout, result record and code names of the index decoder
// ----------------------------------------------------------------------------
package aid_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] COUNT_KEY_RST = 32'h3BD7_A59A;
  localparam logic [7:0]  SUB_KEY_RST   = 8'd39;
  localparam logic [7:0]  XOR_KEY_RST   = 8'hA5;
  localparam logic [7:0]  BASE_KEY_RST  = 8'd27;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_KEY = 2'd0,
    CFG_SUB_KEY   = 2'd1,
    CFG_XOR_KEY   = 2'd2,
    CFG_BASE_KEY  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_OFFSET = 2'd2,
    PH_PAST   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [31:0] count_key;
    logic [7:0]  sub_key;
    logic [7:0]  xor_key;
    logic [7:0]  base_key;
  } keys_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  plain_byte;
    logic [4:0]  byte_in_record;
    logic [31:0] record_index;
    logic        count_valid;
    logic [31:0] entry_count;
    logic        record_done;
    logic [31:0] record_offset;
    logic        len_valid;
    logic [31:0] entry_len;
  } res_t;

endpackage

/* sv/aid_if.sv */
// ----------------------------------------------------------------------------
// aid_if: item channels of the index decoder
// raw byte input channel and decoded result channel, valid/ready
// ----------------------------------------------------------------------------
interface aid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first;

  modport source (output valid, output in_byte, output first, input ready);
  modport sink   (input valid, input in_byte, input first, output ready);
endinterface

interface aid_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic [7:0]  plain_byte;
  logic [4:0]  byte_in_record;
  logic [31:0] record_index;
  logic        count_valid;
  logic [31:0] entry_count;
  logic        record_done;
  logic [31:0] record_offset;
  logic        len_valid;
  logic [31:0] entry_len;

  modport source (
    output valid, output phase, output plain_byte, output byte_in_record,
    output record_index, output count_valid, output entry_count,
    output record_done, output record_offset, output len_valid,
    output entry_len, input ready
  );
  modport sink (
    input valid, input phase, input plain_byte, input byte_in_record,
    input record_index, input count_valid, input entry_count,
    input record_done, input record_offset, input len_valid,
    input entry_len, output ready
  );
endinterface

/* sv/archive_index_decoder.sv */
// ----------------------------------------------------------------------------
// archive_index_decoder: keyed archive index parser
// deciphers the index of a keyed archive one raw byte per item
// ----------------------------------------------------------------------------
// The block takes one raw archive byte per item and returns exactly one
// result item per byte. It accepts a new byte every clock cycle and
// delivers one result per cycle while the output side keeps ready high;
// a byte's result passes through the input register, then the result
// register. The parse state update in aid_step is combinational, so the
// next byte can follow directly while ready stays high. The first four
// bytes build the entry count, later bytes are deciphered into 13-byte
// names (NAME_LEN) and 4-byte offsets, and the length of the previous
// record is reported when an offset completes. Setting first on a byte
// restarts the parse with that byte as header byte 0. Keys must be written
// through the cfg port only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module archive_index_decoder #(
  parameter int unsigned NAME_LEN = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  aid_in_if.sink                         in_if,
  aid_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [aid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import aid_pkg::*;

  // input register stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;

  // result register stage
  logic       out_valid_q;
  res_t       res_q;

  keys_t      keys;
  res_t       res_d;
  logic       adv;       // item moves from input register to result register
  logic       in_fire;

  // flags of the pending result item
  logic       res_count;
  logic       res_done;
  logic       res_len;

  // the held item advances whenever the result register is empty or drained
  assign adv      = s1_valid_q && (!out_valid_q || out_if.ready);
  // input side stays open while the held item moves on this cycle
  assign in_if.ready = !s1_valid_q || adv;
  assign in_fire  = in_if.valid && in_if.ready;

  aid_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .keys_o (keys)
  );

  // parse state lives here and only updates on adv
  aid_step #(
    .NAME_LEN (NAME_LEN)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_byte_i (s1_byte_q),
    .first_i   (s1_first_q),
    .keys_i    (keys),
    .res_o     (res_d)
  );

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload flops, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= in_if.in_byte;
      s1_first_q <= in_if.first;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  // result channel
  assign out_if.valid          = out_valid_q;
  assign out_if.phase          = res_q.phase;
  assign out_if.plain_byte     = res_q.plain_byte;
  assign out_if.byte_in_record = res_q.byte_in_record;
  assign out_if.record_index   = res_q.record_index;
  assign out_if.count_valid    = res_q.count_valid;
  assign out_if.entry_count    = res_q.entry_count;
  assign out_if.record_done    = res_q.record_done;
  assign out_if.record_offset  = res_q.record_offset;
  assign out_if.len_valid      = res_q.len_valid;
  assign out_if.entry_len      = res_q.entry_len;

  assign res_count = out_valid_q && res_q.count_valid;
  assign res_done  = out_valid_q && res_q.record_done;
  assign res_len   = out_valid_q && res_q.len_valid;

  // an advanced item always shows up as a pending result
  `AID_ASSERT(a_adv_fills_out, adv |=> out_valid_q, "advanced item lost")
  // the count only completes during the header
  `AID_ASSERT(a_count_in_header, res_count |-> res_q.phase == PH_HEADER, "count outside header")
  // a record only completes on an offset byte
  `AID_ASSERT(a_done_in_offset, res_done |-> res_q.phase == PH_OFFSET, "done outside offset")
  // a length is only reported with a completed record
  `AID_ASSERT(a_len_with_done, res_len |-> res_q.record_done, "length without record")

endmodule

/* sv/aid_cfg.sv */
// ----------------------------------------------------------------------------
// aid_cfg: key registers
// write-only register file holding the four decipher keys
// ----------------------------------------------------------------------------
module aid_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [aid_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [aid_pkg::CFG_DATA_W-1:0]     data_i,
  output aid_pkg::keys_t                     keys_o
);
  import aid_pkg::*;

  keys_t keys_q;
  keys_t keys_d;

  always_comb begin
    keys_d = keys_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_COUNT_KEY: keys_d.count_key = data_i[31:0];
        CFG_SUB_KEY:   keys_d.sub_key   = data_i[7:0];
        CFG_XOR_KEY:   keys_d.xor_key   = data_i[7:0];
        CFG_BASE_KEY:  keys_d.base_key  = data_i[7:0];
        default:       keys_d = keys_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q.count_key <= COUNT_KEY_RST;
      keys_q.sub_key   <= SUB_KEY_RST;
      keys_q.xor_key   <= XOR_KEY_RST;
      keys_q.base_key  <= BASE_KEY_RST;
    end else begin
      keys_q <= keys_d;
    end
  end

  assign keys_o = keys_q;

endmodule

/* sv/aid_step.sv */
// ----------------------------------------------------------------------------
// aid_step: parse state and per-byte decipher
// holds the parse position and computes one result per advanced byte
// ----------------------------------------------------------------------------
module aid_step #(
  parameter int unsigned NAME_LEN = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic [7:0]     in_byte_i,
  input  logic           first_i,
  input  aid_pkg::keys_t keys_i,
  output aid_pkg::res_t  res_o
);
  import aid_pkg::*;

  localparam int unsigned RecLen = NAME_LEN + 4;
  localparam int unsigned RbW    = $clog2(RecLen);

  logic [2:0]     hdr_pos_q, hdr_pos_d, hp;
  logic [31:0]    count_q, count_d, cnt;
  logic [7:0]     key_pos_q, key_pos_d, kp;
  logic [RbW-1:0] rec_byte_q, rec_byte_d, rb, rb_minus;
  logic [31:0]    rec_num_q, rec_num_d, rn;
  logic [31:0]    off_acc_q, off_acc_d, oacc;
  logic [31:0]    prev_off_q, prev_off_d, poff;
  logic           have_prev_q, have_prev_d, hprev;
  logic [7:0]     p_sub, p_xor, pos_key, p_plain;
  logic [31:0]    rb_ext;

  // restart clears the parse state before this byte is used
  always_comb begin
    hp    = first_i ? '0 : hdr_pos_q;
    cnt   = first_i ? '0 : count_q;
    kp    = first_i ? '0 : key_pos_q;
    rb    = first_i ? '0 : rec_byte_q;
    rn    = first_i ? '0 : rec_num_q;
    oacc  = first_i ? '0 : off_acc_q;
    poff  = first_i ? '0 : prev_off_q;
    hprev = first_i ? 1'b0 : have_prev_q;
  end

  always_comb begin
    hdr_pos_d   = hp;
    count_d     = cnt;
    key_pos_d   = kp;
    rec_byte_d  = rb;
    rec_num_d   = rn;
    off_acc_d   = oacc;
    prev_off_d  = poff;
    have_prev_d = hprev;
    res_o       = '0;
    res_o.phase = PH_HEADER;

    p_sub    = in_byte_i - keys_i.sub_key;
    p_xor    = p_sub ^ keys_i.xor_key;
    pos_key  = keys_i.base_key + kp;
    p_plain  = p_xor - pos_key;
    rb_minus = rb - RbW'(NAME_LEN);
    rb_ext   = 32'(rb);

    if (hp < 3'd4) begin
      count_d[{hp[1:0], 3'b000} +: 8] = cnt[{hp[1:0], 3'b000} +: 8] | in_byte_i;
      hdr_pos_d = hp + 3'd1;
      if (hp == 3'd3) begin
        count_d           = count_d ^ keys_i.count_key;
        res_o.count_valid = 1'b1;
        res_o.entry_count = count_d;
      end
    end else if (rn >= cnt) begin
      res_o.phase = PH_PAST;
    end else begin
      key_pos_d            = kp + 8'd1;
      res_o.plain_byte     = p_plain;
      res_o.byte_in_record = rb_ext[4:0];
      res_o.record_index   = rn;
      if (rb < RbW'(NAME_LEN)) begin
        res_o.phase = PH_NAME;
        rec_byte_d  = rb + RbW'(1);
      end else begin
        res_o.phase = PH_OFFSET;
        off_acc_d[{rb_minus[1:0], 3'b000} +: 8] =
          oacc[{rb_minus[1:0], 3'b000} +: 8] | p_plain;
        if (rb == RbW'(RecLen - 1)) begin
          res_o.record_done   = 1'b1;
          res_o.record_offset = off_acc_d;
          if (hprev) begin
            res_o.len_valid = 1'b1;
            res_o.entry_len = off_acc_d - poff - 32'd1;
          end
          prev_off_d  = off_acc_d;
          have_prev_d = 1'b1;
          off_acc_d   = '0;
          rec_byte_d  = '0;
          rec_num_d   = rn + 32'd1;
        end else begin
          rec_byte_d = rb + RbW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= '0;
      count_q     <= '0;
      key_pos_q   <= '0;
      rec_byte_q  <= '0;
      rec_num_q   <= '0;
      off_acc_q   <= '0;
      prev_off_q  <= '0;
      have_prev_q <= 1'b0;
    end else if (adv_i) begin
      hdr_pos_q   <= hdr_pos_d;
      count_q     <= count_d;
      key_pos_q   <= key_pos_d;
      rec_byte_q  <= rec_byte_d;
      rec_num_q   <= rec_num_d;
      off_acc_q   <= off_acc_d;
      prev_off_q  <= prev_off_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule
